// ===== design/kwm_pkg.sv =====
`default_nettype none
package kwm_pkg;

  localparam int MAX_K  = 15;
  localparam int MAX_W  = 16;
  localparam int HASH_W = 30;
  localparam int POS_W  = 32;
  localparam int K_W    = 4;
  localparam int W_W    = 5;
  localparam int WIDX_W = 4;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic REG_KMER_LEN   = 1'b0;
  localparam logic REG_WINDOW_LEN = 1'b1;

  localparam logic [K_W-1:0] K_RESET = 4'd15;
  localparam logic [W_W-1:0] W_RESET = 5'd10;

  // One classified base, handed from the front to the window engine
  typedef struct packed {
    logic              restart;
    logic              push;
    logic              sym;
    logic              strand;
    logic [HASH_W-1:0] hash;
    logic [POS_W-1:0]  pos;
  } kwm_entry_t;

  typedef struct packed {
    logic [HASH_W-1:0] hash;
    logic              vld;
  } kwm_cand_t;

  function automatic kwm_cand_t min_cand(input kwm_cand_t a, input kwm_cand_t b);
    kwm_cand_t r;
    if (a.vld && (!b.vld || (a.hash <= b.hash))) r = a;
    else r = b;
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== design/kwm_front.sv =====
`default_nettype none
module kwm_front (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         in_valid,
  output logic                        in_ready,
  input  wire  [1:0]                  in_base,
  input  wire                         in_restart,
  input  wire  [kwm_pkg::K_W-1:0]     k_eff,
  output logic                        q_wr,
  output kwm_pkg::kwm_entry_t         q_entry,
  input  wire                         q_full
);

  logic [kwm_pkg::HASH_W-1:0] fwd_r, fwd_nxt, rev_r, rev_nxt;
  logic [kwm_pkg::HASH_W-1:0] fwd_base, rev_base, mask, comp;
  logic [kwm_pkg::K_W-1:0]    seen_r, seen_nxt, seen_base;
  logic [kwm_pkg::POS_W-1:0]  cnt_r, cnt_nxt, here;
  logic [4:0]                 two_k;
  logic                       acc;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;
  assign q_wr     = acc;

  always_comb begin
    fwd_base  = in_restart ? '0 : fwd_r;
    rev_base  = in_restart ? '0 : rev_r;
    seen_base = in_restart ? '0 : seen_r;
    here      = in_restart ? '0 : cnt_r;
    cnt_nxt   = here + kwm_pkg::POS_W'(1);
    seen_nxt  = (seen_base < kwm_pkg::K_W'(kwm_pkg::MAX_K)) ? seen_base + 1'b1 : seen_base;
    two_k     = {k_eff, 1'b0};
    mask      = (kwm_pkg::HASH_W'(1) << two_k) - kwm_pkg::HASH_W'(1);
    comp      = kwm_pkg::HASH_W'(2'd3 - in_base);
    fwd_nxt   = ((fwd_base << 2) | kwm_pkg::HASH_W'(in_base)) & mask;
    rev_nxt   = (((rev_base & mask) >> 2) | (comp << (two_k - 5'd2))) & mask;

    q_entry.restart = in_restart;
    q_entry.push    = (seen_nxt >= k_eff);
    q_entry.sym     = (rev_nxt == fwd_nxt);
    q_entry.strand  = (rev_nxt < fwd_nxt);
    q_entry.hash    = (rev_nxt < fwd_nxt) ? rev_nxt : fwd_nxt;
    q_entry.pos     = here - (kwm_pkg::POS_W'(k_eff) - kwm_pkg::POS_W'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r  <= '0;
      rev_r  <= '0;
      seen_r <= '0;
      cnt_r  <= '0;
    end else if (acc) begin
      fwd_r  <= fwd_nxt;
      rev_r  <= rev_nxt;
      seen_r <= seen_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== design/kwm_queue.sv =====
`default_nettype none
module kwm_queue (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  wr,
  input  kwm_pkg::kwm_entry_t  wr_data,
  output logic                 full,
  input  wire                  rd,
  output kwm_pkg::kwm_entry_t  rd_data,
  output logic                 empty
);

  kwm_pkg::kwm_entry_t mem_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] cnt_r;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign rd_data = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (wr) mem_r[wptr_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (wr) wptr_r <= !wptr_r;
      if (rd) rptr_r <= !rptr_r;
      case ({wr, rd})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== design/kwm_back.sv =====
`default_nettype none
module kwm_back (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire  [kwm_pkg::W_W-1:0]       w_eff,
  input  wire                           q_empty,
  output logic                          q_rd,
  input  kwm_pkg::kwm_entry_t           q_data,
  output logic                          out_valid,
  input  wire                           out_ready,
  output logic [kwm_pkg::HASH_W-1:0]    out_hash_value,
  output logic [kwm_pkg::POS_W-1:0]     out_position,
  output logic                          out_strand,
  output logic                          out_last
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_TREE  = 2'd1;
  localparam logic [1:0] ST_FINAL = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;
  localparam int NW = kwm_pkg::MAX_W;

  logic [1:0] state_r, state_nxt;
  logic [kwm_pkg::W_W-1:0] fill_r, fill_nxt, fill_base;
  logic [kwm_pkg::HASH_W-1:0] hash_r [NW];
  logic [kwm_pkg::POS_W-1:0]  pos_r  [NW];
  logic [NW-1:0] strand_r, sym_r, emitted_r, emitted_nxt;
  logic [NW-1:0] in_win, match;
  kwm_pkg::kwm_cand_t cand [NW];
  kwm_pkg::kwm_cand_t lvl_r [4];
  kwm_pkg::kwm_cand_t lvl_nxt [4];
  kwm_pkg::kwm_cand_t fin;
  logic [kwm_pkg::HASH_W-1:0] m_r;
  logic found_r;
  logic shift;
  logic [kwm_pkg::WIDX_W-1:0] sel;
  logic out_free, emit;

  logic                       out_valid_r, out_valid_nxt;
  logic [kwm_pkg::HASH_W-1:0] out_hash_r;
  logic [kwm_pkg::POS_W-1:0]  out_pos_r;
  logic                       out_strand_r, out_last_r;

  assign out_valid      = out_valid_r;
  assign out_hash_value = out_hash_r;
  assign out_position   = out_pos_r;
  assign out_strand     = out_strand_r;
  assign out_last       = out_last_r;
  assign out_free       = !out_valid_r || out_ready;

  // window region and candidates; index MAX_W-1 holds the newest k-mer
  always_comb begin
    for (int i = 0; i < NW; i++) begin
      in_win[i]     = (6'(i) + 6'(w_eff)) >= 6'(NW);
      cand[i].hash  = hash_r[i];
      cand[i].vld   = in_win[i] && !sym_r[i];
      match[i]      = found_r && cand[i].vld && !emitted_r[i] && (hash_r[i] == m_r);
    end
    for (int j = 0; j < 4; j++) begin
      lvl_nxt[j] = kwm_pkg::min_cand(kwm_pkg::min_cand(cand[4*j], cand[4*j+1]),
                                     kwm_pkg::min_cand(cand[4*j+2], cand[4*j+3]));
    end
    fin = kwm_pkg::min_cand(kwm_pkg::min_cand(lvl_r[0], lvl_r[1]),
                            kwm_pkg::min_cand(lvl_r[2], lvl_r[3]));
    sel = '0;
    for (int i = NW - 1; i >= 0; i--) begin
      if (match[i]) sel = kwm_pkg::WIDX_W'(i);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    fill_base     = q_data.restart ? '0 : fill_r;
    emitted_nxt   = emitted_r;
    out_valid_nxt = out_valid_r && !out_ready;
    q_rd          = 1'b0;
    shift         = 1'b0;
    emit          = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_rd     = 1'b1;
          fill_nxt = fill_base;
          if (q_data.push) begin
            shift       = 1'b1;
            emitted_nxt = {1'b0, emitted_r[NW-1:1]};
            if (fill_base < kwm_pkg::W_W'(NW)) fill_nxt = fill_base + 1'b1;
            if (fill_nxt >= w_eff) state_nxt = ST_TREE;
          end
        end
      end
      ST_TREE:  state_nxt = ST_FINAL;
      ST_FINAL: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (match == '0) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          emit             = 1'b1;
          out_valid_nxt    = 1'b1;
          emitted_nxt[sel] = 1'b1;
          if ((match & (match - 1'b1)) == '0) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      emitted_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      emitted_r   <= emitted_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // window shift line
  always_ff @(posedge clk) begin
    if (shift) begin
      for (int i = 0; i < NW - 1; i++) begin
        hash_r[i] <= hash_r[i+1];
        pos_r[i]  <= pos_r[i+1];
      end
      hash_r[NW-1] <= q_data.hash;
      pos_r[NW-1]  <= q_data.pos;
      strand_r     <= {q_data.strand, strand_r[NW-1:1]};
      sym_r        <= {q_data.sym, sym_r[NW-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_TREE) begin
      for (int j = 0; j < 4; j++) lvl_r[j] <= lvl_nxt[j];
    end
    if (state_r == ST_FINAL) begin
      m_r     <= fin.hash;
      found_r <= fin.vld;
    end
    if (emit) begin
      out_hash_r   <= hash_r[sel];
      out_pos_r    <= pos_r[sel];
      out_strand_r <= strand_r[sel];
      out_last_r   <= ((match & (match - 1'b1)) == '0);
    end
  end

endmodule
`default_nettype wire

// ===== design/kmer_window_minimizer_core.sv =====
`default_nettype none
// A base that closes a full window passes the queue, the window shift, the two-stage min tree and
//   the emitter, which sends one minimizer beat at a time into the output register.
// Throughput: one base per cycle while filling; once full, a base waits for the prior search and beats.
// A two-entry queue lets the front take bases while the window engine works.
// Reset (synchronous, rst_n low): hashes, counters, window fill and emitted marks clear,
//   kmer_len returns to 15 and window_len to 10.
module kmer_window_minimizer_core (
  input  wire                           clk,
  input  wire                           rst_n,
  // base stream
  input  wire                           in_valid,
  output logic                          in_ready,
  input  wire  [1:0]                    in_base,
  input  wire                           in_restart,
  // minimizer stream
  output logic                          out_valid,
  input  wire                           out_ready,
  output logic [kwm_pkg::HASH_W-1:0]    out_hash_value,
  output logic [kwm_pkg::POS_W-1:0]     out_position,
  output logic                          out_strand,
  output logic                          out_last,
  // register port
  input  wire                           psel,
  input  wire                           penable,
  input  wire                           pwrite,
  input  wire  [kwm_pkg::ADDR_W-1:0]    paddr,
  input  wire  [kwm_pkg::DATA_W-1:0]    pwdata,
  output logic [kwm_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);

  logic [kwm_pkg::K_W-1:0] kmer_len_r, kmer_len_nxt, k_eff;
  logic [kwm_pkg::W_W-1:0] window_len_r, window_len_nxt, w_eff;
  logic                    reg_wr;
  logic                    reg_sel;

  kwm_pkg::kwm_entry_t q_wr_data, q_rd_data;
  logic q_wr, q_rd, q_full, q_empty;

  // Register port: zero-wait, write lands in the access phase.
  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign reg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    kmer_len_nxt   = kmer_len_r;
    window_len_nxt = window_len_r;
    if (reg_wr) begin
      case (reg_sel)
        kwm_pkg::REG_KMER_LEN:   kmer_len_nxt   = pwdata[kwm_pkg::K_W-1:0];
        kwm_pkg::REG_WINDOW_LEN: window_len_nxt = pwdata[kwm_pkg::W_W-1:0];
        default: ;
      endcase
    end
    case (reg_sel)
      kwm_pkg::REG_KMER_LEN:   prdata = kwm_pkg::DATA_W'(kmer_len_r);
      kwm_pkg::REG_WINDOW_LEN: prdata = kwm_pkg::DATA_W'(window_len_r);
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kmer_len_r   <= kwm_pkg::K_RESET;
      window_len_r <= kwm_pkg::W_RESET;
    end else begin
      kmer_len_r   <= kmer_len_nxt;
      window_len_r <= window_len_nxt;
    end
  end

  // Clamp out-of-range settings: zero acts as one, oversize acts as the maximum.
  always_comb begin
    if (kmer_len_r == '0) k_eff = kwm_pkg::K_W'(1);
    else if (kmer_len_r > kwm_pkg::K_W'(kwm_pkg::MAX_K)) k_eff = kwm_pkg::K_W'(kwm_pkg::MAX_K);
    else k_eff = kmer_len_r;
    if (window_len_r == '0) w_eff = kwm_pkg::W_W'(1);
    else if (window_len_r > kwm_pkg::W_W'(kwm_pkg::MAX_W)) w_eff = kwm_pkg::W_W'(kwm_pkg::MAX_W);
    else w_eff = window_len_r;
  end

  // Front: roll both strand hashes, decide canonical orientation and whether
  // a complete k-mer exists, then hand the beat to the queue.
  kwm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_base    (in_base),
    .in_restart (in_restart),
    .k_eff      (k_eff),
    .q_wr       (q_wr),
    .q_entry    (q_wr_data),
    .q_full     (q_full)
  );

  // Decouple the front from the window engine.
  kwm_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (q_wr),
    .wr_data (q_wr_data),
    .full    (q_full),
    .rd      (q_rd),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  // Back: shift the window, search the minimum over a registered tree,
  // then emit each not-yet-emitted match oldest first into the output register.
  kwm_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .w_eff          (w_eff),
    .q_empty        (q_empty),
    .q_rd           (q_rd),
    .q_data         (q_rd_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hash_value (out_hash_value),
    .out_position   (out_position),
    .out_strand     (out_strand),
    .out_last       (out_last)
  );

endmodule
`default_nettype wire
